// ===== rtl/bmhq_pkg.sv =====
// ----------------------------------------------------------------------------
// bmhq_pkg: shared types and constants of the binary min-heap queue
// Operation and status codes, the command passed from front to back,
// and the state encoding of the heap engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bmhq_pkg;

  localparam int KEY_W       = 32;
  localparam int CAP_W       = 9;
  localparam int CNT_OUT_W   = 9;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CAP_W-1:0]        CAP_RESET   = 9'd256;
  localparam logic signed [KEY_W-1:0] EMPTY_VALUE = {KEY_W{1'b1}};

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    op_e                      op;
    logic signed [KEY_W-1:0]  key;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_EX_LD,
    S_DN_RD,
    S_DN_CMP,
    S_DONE
  } back_state_e;

endpackage

`default_nettype wire

// ===== rtl/bmhq_front.sv =====
// ----------------------------------------------------------------------------
// bmhq_front: input side of the heap queue
// Accepts input transactions, decodes the operation and buffers the
// commands in a short queue so the engine and the input stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_front (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_ready_o,
  input  wire                                   operation_i,
  input  wire logic signed [bmhq_pkg::KEY_W-1:0] key_i,
  output logic                                  cmd_valid_o,
  input  wire                                   cmd_ready_i,
  output bmhq_pkg::cmd_t                        cmd_o
);
  import bmhq_pkg::*;

  localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  cmd_t           q_mem [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0] q_cnt_q, q_cnt_d;
  logic           push, pop;
  cmd_t           cmd_in;

  assign cmd_in.op  = op_e'(operation_i);
  assign cmd_in.key = key_i;

  assign in_ready_o  = (q_cnt_q != QCW'(QUEUE_DEPTH));
  assign cmd_valid_o = (q_cnt_q != '0);
  assign cmd_o       = q_mem[rd_ptr_q];

  assign push = in_valid_i & in_ready_o;
  assign pop  = cmd_valid_o & cmd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    q_cnt_d  = q_cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      q_cnt_d = q_cnt_q + 1'b1;
    end else if (pop && !push) begin
      q_cnt_d = q_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      q_cnt_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      q_cnt_q  <= q_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd_in;
    end
  end

`ifndef SYNTHESIS
  a_q_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt_q <= QCW'(QUEUE_DEPTH))
    else $error("command queue overfilled");
`endif

endmodule

`default_nettype wire

// ===== rtl/bmhq_back.sv =====
// ----------------------------------------------------------------------------
// bmhq_back: heap engine
// Executes insert and extract-min commands on the key store with a hole-based
// sift up / sift down, a key store read and a compare-and-write per tree level,
// and holds the result in an output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_back #(
  parameter int MAX_ENTRIES = 256
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire logic [bmhq_pkg::CAP_W-1:0]        capacity_i,
  input  wire                                    cmd_valid_i,
  output logic                                   cmd_ready_o,
  input  wire bmhq_pkg::cmd_t                    cmd_i,
  output logic                                   out_valid_o,
  input  wire                                    out_ready_i,
  output logic signed [bmhq_pkg::KEY_W-1:0]      value_o,
  output logic [1:0]                             status_o,
  output logic [bmhq_pkg::CNT_OUT_W-1:0]         count_o
);
  import bmhq_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int IW = AW + 2;

  // key store: one write port, two registered read ports
  logic signed [KEY_W-1:0] mem [MAX_ENTRIES];
  logic signed [KEY_W-1:0] rd0_q, rd1_q;
  logic [AW-1:0]           ra0, ra1, waddr;
  logic signed [KEY_W-1:0] wdata;
  logic                    we;

  back_state_e             state_q, state_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [AW-1:0]           pos_q, pos_d;
  logic signed [KEY_W-1:0] key_q, key_d;
  logic signed [KEY_W-1:0] res_val_q, res_val_d;
  status_e                 res_st_q, res_st_d;

  logic                    out_valid_q, out_valid_d;
  logic signed [KEY_W-1:0] out_val_q;
  status_e                 out_st_q;
  logic [CNT_OUT_W-1:0]    out_cnt_q;
  logic                    out_load;

  logic [AW-1:0]           parent;
  logic [IW-1:0]           lc_idx, rc_idx;
  logic                    left_ok, right_ok, take_l, take_r;
  logic signed [KEY_W-1:0] best_val;
  logic                    full;

  assign parent = AW'((pos_q - 1'b1) >> 1);
  assign lc_idx = IW'({pos_q, 1'b1});
  assign rc_idx = lc_idx + 1'b1;

  assign left_ok  = (32'(lc_idx) < 32'(cnt_q));
  assign right_ok = (32'(rc_idx) < 32'(cnt_q));
  assign take_l   = left_ok && (rd0_q < key_q);
  assign best_val = take_l ? rd0_q : key_q;
  assign take_r   = right_ok && (rd1_q < best_val);

  // limit saturates at the store size
  assign full = (32'(cnt_q) >= 32'(capacity_i)) || (32'(cnt_q) >= 32'(MAX_ENTRIES));

  assign cmd_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    key_d     = key_q;
    res_val_d = res_val_q;
    res_st_d  = res_st_q;
    ra0       = '0;
    ra1       = AW'(cnt_q - 1'b1);
    we        = 1'b0;
    waddr     = pos_q;
    wdata     = key_q;
    out_load  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          res_val_d = '0;
          res_st_d  = ST_OK;
          unique case (cmd_i.op)
            OP_INSERT: begin
              if (full) begin
                res_st_d = ST_FULL;
                state_d  = S_DONE;
              end else begin
                key_d   = cmd_i.key;
                pos_d   = AW'(cnt_q);
                cnt_d   = cnt_q + 1'b1;
                state_d = S_UP_CHK;
              end
            end
            OP_EXTRACT: begin
              if (cnt_q == '0) begin
                res_val_d = EMPTY_VALUE;
                res_st_d  = ST_EMPTY;
                state_d   = S_DONE;
              end else begin
                // root and last entry are being read this cycle
                state_d = S_EX_LD;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_UP_CHK: begin
        if (pos_q == '0) begin
          we      = 1'b1;
          state_d = S_DONE;
        end else begin
          ra0     = parent;
          state_d = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        we = 1'b1;
        if (key_q < rd0_q) begin
          wdata   = rd0_q;
          pos_d   = parent;
          state_d = S_UP_CHK;
        end else begin
          state_d = S_DONE;
        end
      end

      S_EX_LD: begin
        res_val_d = rd0_q;
        cnt_d     = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          state_d = S_DONE;
        end else begin
          key_d   = rd1_q;
          pos_d   = '0;
          state_d = S_DN_RD;
        end
      end

      S_DN_RD: begin
        ra0     = lc_idx[AW-1:0];
        ra1     = rc_idx[AW-1:0];
        state_d = S_DN_CMP;
      end

      S_DN_CMP: begin
        we = 1'b1;
        if (take_r) begin
          wdata   = rd1_q;
          pos_d   = rc_idx[AW-1:0];
          state_d = S_DN_RD;
        end else if (take_l) begin
          wdata   = rd0_q;
          pos_d   = lc_idx[AW-1:0];
          state_d = S_DN_RD;
        end else begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    key_q     <= key_d;
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
    if (out_load) begin
      out_val_q <= res_val_q;
      out_st_q  <= res_st_q;
      out_cnt_q <= CNT_OUT_W'(cnt_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd0_q <= mem[ra0];
    rd1_q <= mem[ra1];
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_val_q;
  assign status_o    = out_st_q;
  assign count_o     = out_cnt_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_ENTRIES))
    else $error("entry count above store size");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |->
      (cnt_q == $past(cnt_q) + 1'b1 || cnt_q + 1'b1 == $past(cnt_q)))
    else $error("entry count moved by more than one");

  a_sift_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UP_CHK || state_q == S_DN_RD) |-> (32'(pos_q) < 32'(cnt_q)))
    else $error("sift position outside the heap");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_EMPTY) |->
      (value_o == EMPTY_VALUE && count_o == '0))
    else $error("empty extract result malformed");
`endif

endmodule

`default_nettype wire

// ===== rtl/binary_min_heap_queue_top.sv =====
// ----------------------------------------------------------------------------
// binary_min_heap_queue_top: min-heap priority queue of signed 32-bit keys
// Insert and extract-min commands, one result transaction per command.
// ----------------------------------------------------------------------------
// Each command gives one result: the extracted key (-1 on an empty heap, 0 for
// inserts), a status (ok, full, empty) and the entry count afterwards. Commands
// are buffered in a two-deep queue, so input transactions are still taken while
// the engine works and while a result waits in the output register, until the
// queue is full. The engine handles one command at a time, from taking it to
// loading the output register: an insert places the key and sifts it up, an
// extract reads the root and the last entry and, unless it removed the only
// entry, sifts the last entry down from the root; a refused insert or an empty
// extract goes straight to the output. At most clog2(MAX_ENTRIES) levels are
// sifted, and a result waits while the output register is full; each level costs
// a registered key store read followed by a compare-and-write step. The store
// needs no clearing after reset. Capacity must be written only while idle, by the
// user; the block itself does not enforce it. Values above MAX_ENTRIES act as MAX_ENTRIES.
`default_nettype none

module binary_min_heap_queue_top #(
  parameter int MAX_ENTRIES = 256
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [bmhq_pkg::CAP_W-1:0]       cfg_capacity_i,
  input  wire                                   in_valid_i,
  output logic                                  in_ready_o,
  input  wire                                   operation_i,
  input  wire logic signed [bmhq_pkg::KEY_W-1:0] key_i,
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  output logic signed [bmhq_pkg::KEY_W-1:0]     value_o,
  output logic [1:0]                            status_o,
  output logic [bmhq_pkg::CNT_OUT_W-1:0]        count_o
);
  import bmhq_pkg::*;

  logic [CAP_W-1:0] cap_q;
  logic             cmd_valid, cmd_ready;
  cmd_t             cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_capacity_i;
    end
  end

  bmhq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .key_i       (key_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  bmhq_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .capacity_i  (cap_q),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o),
    .status_o    (status_o),
    .count_o     (count_o)
  );

endmodule

`default_nettype wire

// ===== sim/binary_min_heap_queue_top_tb.sv =====
// ----------------------------------------------------------------------------
// binary_min_heap_queue_top_tb: self-checking bench for the min-heap queue
// Insert/extract commands go in through a bursty driver and results are
// checked against a behavioral heap updated on every accepted command. The
// run steps through several capacity settings, full and empty heaps and a
// long output stall that backs up the command input.
// ----------------------------------------------------------------------------

module binary_min_heap_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bmhq_pkg::*;

  localparam int HEAP_DEPTH  = 256;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 40;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_RANDOM,
    RDY_PATTERN
  } ready_mode_e;

  typedef struct {
    logic signed [KEY_W-1:0] value;
    status_e                 status;
    logic [CNT_OUT_W-1:0]    count;
  } heap_result_t;

  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    cfg_valid_i    = 1'b0;
  logic                    cfg_ready_o;
  logic [CAP_W-1:0]        cfg_capacity_i = CAP_RESET;
  logic                    in_valid_i     = 1'b0;
  logic                    in_ready_o;
  logic                    operation_i    = 1'b0;
  logic signed [KEY_W-1:0] key_i          = '0;
  logic                    out_valid_o;
  logic                    out_ready_i    = 1'b0;
  logic signed [KEY_W-1:0] value_o;
  logic [1:0]              status_o;
  logic [CNT_OUT_W-1:0]    count_o;

  binary_min_heap_queue_top #(
    .MAX_ENTRIES (HEAP_DEPTH)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_capacity_i (cfg_capacity_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .key_i          (key_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .value_o        (value_o),
    .status_o       (status_o),
    .count_o        (count_o)
  );

  always #4 clk_i = ~clk_i;

  // Behavioral heap
  logic signed [KEY_W-1:0] heap_keys [HEAP_DEPTH];
  int                      heap_size    = 0;
  logic [CAP_W-1:0]        capacity_reg = CAP_RESET;
  heap_result_t            predicted_results [$];

  cmd_t        cmd_backlog [$];
  int          cmds_queued    = 0;
  int          cmds_accepted  = 0;
  int          fail_count     = 0;
  bit          cmd_taken      = 1'b0;
  bit          sender_gaps_on = 1'b1;
  int          burst_left     = 0;
  int          send_gap       = 0;
  ready_mode_e ready_mode     = RDY_ALWAYS;
  logic [7:0]  ready_pattern  = 8'b1011_0110;
  bit          hold_request   = 1'b0;
  int          hold_left      = 0;

  task automatic heap_apply(input op_e op, input logic signed [KEY_W-1:0] key);
    heap_result_t            res;
    int                      pos;
    int                      up;
    int                      lc;
    int                      rc;
    int                      best;
    int                      limit;
    logic signed [KEY_W-1:0] tmp;
    limit      = (int'(capacity_reg) > HEAP_DEPTH) ? HEAP_DEPTH : int'(capacity_reg);
    res.value  = '0;
    res.status = ST_OK;
    if (op == OP_INSERT) begin
      if (heap_size >= limit) begin
        res.status = ST_FULL;
      end else begin
        heap_keys[heap_size] = key;
        pos = heap_size;
        heap_size++;
        while (pos != 0) begin
          up = (pos - 1) / 2;
          if (!(heap_keys[pos] < heap_keys[up])) break;
          tmp            = heap_keys[pos];
          heap_keys[pos] = heap_keys[up];
          heap_keys[up]  = tmp;
          pos            = up;
        end
      end
    end else if (heap_size == 0) begin
      res.value  = EMPTY_VALUE;
      res.status = ST_EMPTY;
    end else begin
      res.value = heap_keys[0];
      heap_size--;
      heap_keys[0] = heap_keys[heap_size];
      pos = 0;
      while (1) begin
        lc   = 2 * pos + 1;
        rc   = 2 * pos + 2;
        best = pos;
        // left child wins ties: only a strictly smaller key moves best
        if (lc < heap_size && heap_keys[lc] < heap_keys[best]) best = lc;
        if (rc < heap_size && heap_keys[rc] < heap_keys[best]) best = rc;
        if (best == pos) break;
        tmp             = heap_keys[pos];
        heap_keys[pos]  = heap_keys[best];
        heap_keys[best] = tmp;
        pos             = best;
      end
    end
    res.count = heap_size[CNT_OUT_W-1:0];
    predicted_results.push_back(res);
  endtask

  // Command driver: acceptance seen at the rising edge, next command at the falling edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      heap_apply(op_e'(operation_i), key_i);
      cmds_accepted++;
      cmd_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    cmd_t next_cmd;
    if (cmd_taken || !in_valid_i) begin
      cmd_taken = 1'b0;
      if (send_gap != 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (rst_ni && cmd_backlog.size() != 0) begin
        next_cmd = cmd_backlog.pop_front();
        operation_i <= next_cmd.op;
        key_i       <= next_cmd.key;
        in_valid_i  <= 1'b1;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 20);
          send_gap   = sender_gaps_on ? $urandom_range(1, 10) : 0;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      case (ready_mode)
        RDY_ALWAYS: out_ready_i <= 1'b1;
        RDY_RANDOM: out_ready_i <= ($urandom_range(0, 3) != 0);
        default: begin
          out_ready_i   <= ready_pattern[0];
          ready_pattern  = {ready_pattern[0], ready_pattern[7:1]};
        end
      endcase
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    heap_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (predicted_results.size() == 0) begin
        $error("unexpected result transaction: value %0d status %0d count %0d",
               value_o, status_o, count_o);
        fail_count++;
      end else begin
        exp_res = predicted_results.pop_front();
        if (value_o !== exp_res.value) begin
          $error("value: expected %0d, actual %0d", exp_res.value, value_o);
          fail_count++;
        end
        if (status_o !== exp_res.status) begin
          $error("status: expected %0d, actual %0d", exp_res.status, status_o);
          fail_count++;
        end
        if (count_o !== exp_res.count) begin
          $error("count: expected %0d, actual %0d", exp_res.count, count_o);
          fail_count++;
        end
      end
    end
  end

  task automatic add_cmd(input op_e op, input logic signed [KEY_W-1:0] key);
    cmd_t c;
    c.op  = op;
    c.key = key;
    cmd_backlog.push_back(c);
    cmds_queued++;
  endtask

  task automatic add_random_cmds(input int n, input int insert_pct);
    logic signed [KEY_W-1:0] key;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1: key = int'($urandom_range(0, 15)) - 8;  // narrow range, lots of ties
        2: begin
          case ($urandom_range(0, 3))
            0:       key = 32'sh8000_0000;
            1:       key = 32'sh7fff_ffff;
            2:       key = -32'sd1;
            default: key = '0;
          endcase
        end
        default: key = $urandom();
      endcase
      add_cmd(($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_EXTRACT, key);
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (cmds_accepted != cmds_queued || predicted_results.size() != 0);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i    <= 1'b1;
    cfg_capacity_i <= cap;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    capacity_reg = cap;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic shuffle_idling();
    ready_mode     = ready_mode_e'($urandom_range(0, 2));
    ready_pattern  = 8'($urandom_range(1, 255));
    sender_gaps_on = ($urandom_range(0, 2) != 0);
  endtask

  initial begin
    logic [CAP_W-1:0] cap;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty extract, key extremes, ties, full drain
    add_cmd(OP_EXTRACT, 32'sd0);
    add_cmd(OP_INSERT, 32'sd0);
    add_cmd(OP_INSERT, 32'sh7fff_ffff);
    add_cmd(OP_INSERT, 32'sh8000_0000);
    add_cmd(OP_INSERT, -32'sd1);
    add_cmd(OP_INSERT, 32'sd1);
    add_cmd(OP_INSERT, 32'sd5);
    add_cmd(OP_INSERT, 32'sd5);
    add_cmd(OP_INSERT, -32'sd1);
    for (int i = 0; i < 8; i++) add_cmd(OP_EXTRACT, 32'sd0);
    add_cmd(OP_EXTRACT, 32'sh7fff_ffff);  // empty again, key must be ignored
    add_cmd(OP_INSERT, 32'sh5555_5555);
    add_cmd(OP_INSERT, 32'shAAAA_AAAA);
    add_cmd(OP_EXTRACT, 32'sd0);
    add_cmd(OP_EXTRACT, 32'sd0);

    // zero capacity refuses every insert
    write_capacity(9'd0);
    add_cmd(OP_INSERT, 32'sd3);
    add_cmd(OP_INSERT, 32'sh8000_0000);
    add_cmd(OP_EXTRACT, 32'sd0);
    add_cmd(OP_INSERT, 32'sd7);

    write_capacity(9'd1);
    shuffle_idling();
    add_random_cmds(60, 50);

    // above store size: saturates, fill to the top and beyond
    write_capacity(9'd511);
    shuffle_idling();
    add_random_cmds(270, 100);
    add_random_cmds(40, 80);

    // capacity below current count: inserts refused, extracts still work
    write_capacity(9'd5);
    shuffle_idling();
    add_random_cmds(30, 50);

    write_capacity(9'd256);
    shuffle_idling();
    add_random_cmds(300, 15);

    // long output stall with the sender offering back to back
    write_capacity(9'd40);
    ready_mode     = RDY_ALWAYS;
    sender_gaps_on = 1'b0;
    send_gap       = 0;
    add_random_cmds(110, 60);
    hold_request   = 1'b1;

    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 3))
        0:       cap = 9'($urandom_range(1, 3));
        1:       cap = 9'($urandom_range(257, 511));
        default: cap = 9'($urandom_range(1, 256));
      endcase
      write_capacity(cap);
      shuffle_idling();
      add_random_cmds(110, $urandom_range(35, 75));
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && predicted_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== binary_min_heap_queue_top.f =====
rtl/bmhq_pkg.sv
rtl/bmhq_front.sv
rtl/bmhq_back.sv
rtl/binary_min_heap_queue_top.sv
sim/binary_min_heap_queue_top_tb.sv
